FILE: rtl/sfr_pkg.sv
// ----------------------------------------------------------------------------
// sfr_pkg
// Shared types, codes and the byte-wide CRC-16/Modbus update for the
// serial frame receiver.
// ----------------------------------------------------------------------------
package sfr_pkg;

	localparam logic [15:0] CRC_INIT = 16'hFFFF;
	localparam logic [15:0] CRC_POLY = 16'hA001;
	localparam logic [15:0] TICK_MAX = 16'hFFFF;

	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_HDR_FIRST  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_HDR_SECOND = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT    = 2'd2;

	localparam logic [7:0]  HDR_FIRST_RST  = 8'h55;
	localparam logic [7:0]  HDR_SECOND_RST = 8'hAA;
	localparam logic [15:0] TIMEOUT_RST    = 16'd50;

	typedef enum logic [2:0] {
		ST_HDR1   = 3'd0,
		ST_HDR2   = 3'd1,
		ST_LEN    = 3'd2,
		ST_DATA   = 3'd3,
		ST_CRC_HI = 3'd4,
		ST_CRC_LO = 3'd5
	} parse_t;

	typedef enum logic [1:0] {
		KIND_PAYLOAD = 2'd0,
		KIND_GOOD    = 2'd1,
		KIND_BAD     = 2'd2
	} kind_t;

	typedef struct packed {
		kind_t      kind;
		logic [7:0] payload_byte;
		logic [7:0] payload_index;
		logic [7:0] frame_length;
	} result_t;

	typedef struct packed {
		logic [7:0]  header_first;
		logic [7:0]  header_second;
		logic [15:0] timeout_ticks;
	} cfg_t;

	// reflected crc, one byte, lsb first
	function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'h00, b};
		for (int k = 0; k < 8; k++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

endpackage

FILE: rtl/serial_frame_receiver_crc16_top.sv
// ----------------------------------------------------------------------------
// serial_frame_receiver_crc16_top
// Serial frame deframer with CRC-16/Modbus check.
// ----------------------------------------------------------------------------
// Usage:
//   s_* stream: one item per received byte (s_tuser = 0) or timer tick
//   (s_tuser = 1). m_* stream: payload bytes with their index, and one good
//   or bad verdict after the two crc bytes of each frame.
//   cfg_* channel: writes header_first (0), header_second (1) and
//   timeout_ticks (2); always ready, write only while the block is idle.
// Timing: an accepted item is registered in the input stage, then parsed, and
//   its result is registered in the result register, which drives m_tvalid;
//   while the result register is full, the item waits in the input stage.
// Throughput: one item per cycle while the result register can take it, set
//   by the combinational parse and byte-wide crc update from input stage to result register.
// Reset: parser waits for the first header, crc = 0xFFFF, tick timer clear,
//   registers take 0x55, 0xAA and 50.
// Stall: while m_tready is low with a result pending, the input stage holds
//   one item and s_tready drops once it is full; ticks and bytes with no
//   result still pass as soon as the result register can take them.
// ----------------------------------------------------------------------------
module serial_frame_receiver_crc16_top (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [7:0]                    s_tdata,   // rx_byte
	input  logic [0:0]                    s_tuser,   // op
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [23:0]                   m_tdata,   // payload_byte, payload_index, frame_length
	output logic [1:0]                    m_tuser,   // kind
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [sfr_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [15:0]                   cfg_data
);
	import sfr_pkg::*;

	cfg_t       cfg_q;
	logic       valid_s1;
	logic       op_s1;
	logic [7:0] byte_s1;
	logic       out_ready;
	logic       adv;
	logic       res_valid;
	result_t    res;

	assign cfg_ready = 1'b1;
	assign adv       = valid_s1 && out_ready;
	assign s_tready  = !valid_s1 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.header_first  <= HDR_FIRST_RST;
			cfg_q.header_second <= HDR_SECOND_RST;
			cfg_q.timeout_ticks <= TIMEOUT_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_HDR_FIRST:  cfg_q.header_first  <= cfg_data[7:0];
				CFG_HDR_SECOND: cfg_q.header_second <= cfg_data[7:0];
				CFG_TIMEOUT:    cfg_q.timeout_ticks <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			op_s1   <= s_tuser[0];
			byte_s1 <= s_tdata;
		end
	end

	sfr_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.step_en   (adv),
		.op        (op_s1),
		.rx_byte   (byte_s1),
		.cfg       (cfg_q),
		.res_valid (res_valid),
		.res       (res)
	);

	sfr_out_reg u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.take      (adv),
		.res_valid (res_valid),
		.res       (res),
		.ready     (out_ready),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

endmodule

FILE: rtl/sfr_parser.sv
// ----------------------------------------------------------------------------
// sfr_parser
// Frame parse state, tick timer and running CRC; one item per enabled cycle.
// ----------------------------------------------------------------------------
module sfr_parser (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            step_en,
	input  logic            op,
	input  logic [7:0]      rx_byte,
	input  sfr_pkg::cfg_t   cfg,
	output logic            res_valid,
	output sfr_pkg::result_t res
);
	import sfr_pkg::*;

	parse_t      step_q, step_d, step_eff;
	logic [7:0]  len_q, len_d;
	logic [7:0]  seen_q, seen_d;
	logic [15:0] crc_q, crc_d, crc_base, crc_upd;
	logic [7:0]  crc_hi_q, crc_hi_d;
	logic [15:0] tick_q, tick_d, tick_inc;
	logic        timed_q, timed_d;
	logic [7:0]  seen_inc;

	assign tick_inc = (tick_q == TICK_MAX) ? tick_q : tick_q + 16'd1;
	assign step_eff = timed_q ? ST_HDR1 : step_q;
	assign crc_base = (step_eff == ST_LEN) ? CRC_INIT : crc_q;
	assign crc_upd  = crc16_byte(crc_base, rx_byte);
	assign seen_inc = seen_q + 8'd1;

	// next state
	always_comb begin
		step_d   = step_q;
		len_d    = len_q;
		seen_d   = seen_q;
		crc_d    = crc_q;
		crc_hi_d = crc_hi_q;
		tick_d   = tick_q;
		timed_d  = timed_q;
		if (op) begin
			tick_d = tick_inc;
			if (tick_inc >= cfg.timeout_ticks) begin
				timed_d = 1'b1;
			end
		end else begin
			step_d = step_eff;
			case (step_eff)
				ST_HDR1: begin
					if (rx_byte == cfg.header_first) begin
						timed_d = 1'b0;
						tick_d  = '0;
						step_d  = ST_HDR2;
					end
				end
				ST_HDR2: begin
					step_d = (rx_byte == cfg.header_second) ? ST_LEN : ST_HDR1;
				end
				ST_LEN: begin
					len_d  = rx_byte;
					seen_d = '0;
					crc_d  = crc_upd;
					step_d = (rx_byte == 8'd0) ? ST_CRC_HI : ST_DATA;
				end
				ST_DATA: begin
					crc_d  = crc_upd;
					seen_d = seen_inc;
					if (seen_inc == len_q) begin
						step_d = ST_CRC_HI;
					end
				end
				ST_CRC_HI: begin
					crc_hi_d = rx_byte;
					step_d   = ST_CRC_LO;
				end
				ST_CRC_LO: begin
					step_d = ST_HDR1;
				end
				default: begin
					step_d = ST_HDR1;
				end
			endcase
		end
	end

	// result
	always_comb begin
		res_valid         = 1'b0;
		res.kind          = KIND_PAYLOAD;
		res.payload_byte  = '0;
		res.payload_index = '0;
		res.frame_length  = len_q;
		if (!op) begin
			case (step_eff)
				ST_DATA: begin
					res_valid         = 1'b1;
					res.payload_byte  = rx_byte;
					res.payload_index = seen_q;
				end
				ST_CRC_LO: begin
					res_valid = 1'b1;
					res.kind  = ({crc_hi_q, rx_byte} == crc_q) ? KIND_GOOD : KIND_BAD;
				end
				default: begin
					res_valid = 1'b0;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q   <= ST_HDR1;
			len_q    <= '0;
			seen_q   <= '0;
			crc_q    <= CRC_INIT;
			crc_hi_q <= '0;
			tick_q   <= '0;
			timed_q  <= 1'b0;
		end else if (step_en) begin
			step_q   <= step_d;
			len_q    <= len_d;
			seen_q   <= seen_d;
			crc_q    <= crc_d;
			crc_hi_q <= crc_hi_d;
			tick_q   <= tick_d;
			timed_q  <= timed_d;
		end
	end

	a_tick_silent: assert property (@(posedge clk) disable iff (!arst_n)
		step_en && op |-> !res_valid)
		else $error("tick produced a result");

	a_verdict_restarts: assert property (@(posedge clk) disable iff (!arst_n)
		step_en && res_valid && res.kind != KIND_PAYLOAD |=> step_q == ST_HDR1)
		else $error("parser did not restart after verdict");

	a_index_in_frame: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.kind == KIND_PAYLOAD |-> res.payload_index < res.frame_length)
		else $error("payload index beyond frame length");

	a_header_clears_timer: assert property (@(posedge clk) disable iff (!arst_n)
		step_en && !op && step_eff == ST_HDR1 && rx_byte == cfg.header_first
		|=> tick_q == 16'd0 && !timed_q)
		else $error("timer not cleared on frame start");

endmodule

FILE: rtl/sfr_out_reg.sv
// ----------------------------------------------------------------------------
// sfr_out_reg
// Result register toward the master-side stream.
// ----------------------------------------------------------------------------
module sfr_out_reg (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             take,
	input  logic             res_valid,
	input  sfr_pkg::result_t res,
	output logic             ready,
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [23:0]      m_tdata,  // payload_byte, payload_index, frame_length
	output logic [1:0]       m_tuser   // kind
);
	import sfr_pkg::*;

	logic    valid_q;
	result_t data_q;

	assign ready    = !valid_q || m_tready;
	assign m_tvalid = valid_q;
	assign m_tdata  = {data_q.frame_length, data_q.payload_index, data_q.payload_byte};
	assign m_tuser  = data_q.kind;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ready) begin
			valid_q <= take && res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ready && take && res_valid) begin
			data_q <= res;
		end
	end

	a_hold_while_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q && !m_tready |=> valid_q && $stable(data_q))
		else $error("result lost while stalled");

	a_no_take_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		take |-> ready)
		else $error("item advanced into a full result register");

	a_kind_legal: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q |-> data_q.kind != 2'd3)
		else $error("illegal result kind");

endmodule

FILE: test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the serial frame receiver. A directed table covers
// headers, zero length, bad crc, a bad second header and payload extremes.
// Stale-frame runs follow at the shortest and longest timeouts. A frame of
// the longest length runs under a long receiver hold-off. Randomized frames
// then run, clean, corrupted, cut short or mixed with noise and ticks, over
// several register settings. Each item is predicted and each result is
// compared in order.
// ----------------------------------------------------------------------------
module tb_top;
	import sfr_pkg::*;

	localparam int RX_HOLD_CYCLES = 200;
	localparam int SETTLE_CYCLES  = 4;
	localparam int FRAME_TARGET   = 100;

	typedef enum {FROM_LIT, FROM_CRC_HI, FROM_CRC_LO} byte_src_t;
	typedef enum {CHK_MODEL, CHK_NONE, CHK_RESULT} row_chk_t;

	typedef struct {
		logic       op;
		byte_src_t  src;
		logic [7:0] lit;
		row_chk_t   chk;
		result_t    res;
	} stim_row_t;

	logic                 clk;
	logic                 arst_n;
	logic                 s_tvalid;
	logic                 s_tready;
	logic [7:0]           s_tdata;    // rx_byte
	logic [0:0]           s_tuser;    // op
	logic                 m_tvalid;
	logic                 m_tready;
	logic [23:0]          m_tdata;    // payload_byte, payload_index, frame_length
	logic [1:0]           m_tuser;    // kind
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [15:0]          cfg_data;

	// predictor copy of registers and parser state
	logic [7:0]  cfg_hf;
	logic [7:0]  cfg_hs;
	logic [15:0] cfg_timeout;
	parse_t      fr_step;
	logic [7:0]  fr_len;
	logic [7:0]  fr_count;
	logic [15:0] fr_crc;
	logic [7:0]  fr_crc_hi;
	logic [15:0] tick_cnt;
	bit          stale;

	result_t   frame_results_due[$];
	stim_row_t directed_rows[$];
	result_t   want;

	bit tx_no_idle;
	bit rx_no_idle;
	bit hold_out_req;

	int n_fail;
	int n_items;
	int frame_items;
	int n_payload;
	int n_good;
	int n_bad;
	int n_cfg;
	int n_stall;

	serial_frame_receiver_crc16_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		clk = 1'b1;
		#1;
		clk = 1'b0;
		#1;
	end

	function automatic logic [15:0] modbus_crc_next(input logic [15:0] acc, input logic [7:0] d);
		logic [15:0] v;
		v = acc ^ {8'h00, d};
		repeat (8) v = v[0] ? ((v >> 1) ^ CRC_POLY) : (v >> 1);
		return v;
	endfunction

	function automatic void deframer_reset();
		cfg_hf      = HDR_FIRST_RST;
		cfg_hs      = HDR_SECOND_RST;
		cfg_timeout = TIMEOUT_RST;
		fr_step     = ST_HDR1;
		fr_len      = 8'h00;
		fr_count    = 8'h00;
		fr_crc      = CRC_INIT;
		fr_crc_hi   = 8'h00;
		tick_cnt    = 16'h0000;
		stale       = 1'b0;
	endfunction

	// advances the parser copy by one item, returns the result it causes
	function automatic void deframe_step(input logic op, input logic [7:0] b,
			output bit got, output result_t r);
		got             = 1'b0;
		r.kind          = KIND_PAYLOAD;
		r.payload_byte  = 8'h00;
		r.payload_index = 8'h00;
		r.frame_length  = 8'h00;
		if (op) begin
			if (tick_cnt != TICK_MAX)
				tick_cnt = tick_cnt + 16'd1;
			if (tick_cnt >= cfg_timeout)
				stale = 1'b1;
			return;
		end
		if (stale)
			fr_step = ST_HDR1;
		case (fr_step)
			ST_HDR1: begin
				if (b == cfg_hf) begin
					stale    = 1'b0;
					tick_cnt = 16'h0000;
					fr_step  = ST_HDR2;
				end
			end
			ST_HDR2: begin
				fr_step = (b == cfg_hs) ? ST_LEN : ST_HDR1;
			end
			ST_LEN: begin
				fr_len   = b;
				fr_count = 8'h00;
				fr_crc   = modbus_crc_next(CRC_INIT, b);
				fr_step  = (b == 8'h00) ? ST_CRC_HI : ST_DATA;
			end
			ST_DATA: begin
				got             = 1'b1;
				r.payload_byte  = b;
				r.payload_index = fr_count;
				r.frame_length  = fr_len;
				fr_crc          = modbus_crc_next(fr_crc, b);
				fr_count        = fr_count + 8'd1;
				if (fr_count == fr_len)
					fr_step = ST_CRC_HI;
			end
			ST_CRC_HI: begin
				fr_crc_hi = b;
				fr_step   = ST_CRC_LO;
			end
			ST_CRC_LO: begin
				got            = 1'b1;
				r.kind         = ({fr_crc_hi, b} == fr_crc) ? KIND_GOOD : KIND_BAD;
				r.frame_length = fr_len;
				fr_step        = ST_HDR1;
			end
			default: begin
				fr_step = ST_HDR1;
			end
		endcase
	endfunction

	task automatic add_row(input logic op, input byte_src_t src, input logic [7:0] lit,
			input row_chk_t chk, input kind_t k, input logic [7:0] pb,
			input logic [7:0] pi, input logic [7:0] fl);
		stim_row_t row;
		row.op                = op;
		row.src               = src;
		row.lit               = lit;
		row.chk               = chk;
		row.res.kind          = k;
		row.res.payload_byte  = pb;
		row.res.payload_index = pi;
		row.res.frame_length  = fl;
		directed_rows.push_back(row);
	endtask

	task automatic send_item(input logic op, input logic [7:0] b, output bit got,
			output result_t r);
		int gap;
		gap = tx_no_idle ? 0 : $urandom_range(0, 15);
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= b;
		do @(posedge clk); while (!(s_tvalid && s_tready));
		deframe_step(op, b, got, r);
		n_items++;
	endtask

	task automatic send_checked(input logic op, input logic [7:0] b);
		bit      got;
		result_t r;
		send_item(op, b, got, r);
		if (got)
			frame_results_due.push_back(r);
	endtask

	task automatic send_ticks(input int n);
		repeat (n) send_checked(1'b1, 8'($urandom));
	endtask

	// builds one frame from the current headers; cut stops it early
	task automatic send_frame(input int len, input bit corrupt, input int cut,
			input int tick_pct);
		logic [7:0]  seq[$];
		logic [15:0] crc;
		logic [7:0]  d;
		int          i;
		crc = modbus_crc_next(CRC_INIT, 8'(len));
		seq.push_back(cfg_hf);
		seq.push_back(cfg_hs);
		seq.push_back(8'(len));
		for (i = 0; i < len; i++) begin
			d = 8'($urandom);
			seq.push_back(d);
			crc = modbus_crc_next(crc, d);
		end
		if (corrupt)
			crc = crc ^ 16'(1 << $urandom_range(0, 15));
		seq.push_back(crc[15:8]);
		seq.push_back(crc[7:0]);
		for (i = 0; i < seq.size() && i < cut; i++) begin
			if ($urandom_range(0, 99) < tick_pct)
				send_ticks($urandom_range(1, 3));
			send_checked(1'b0, seq[i]);
			frame_items++;
		end
	endtask

	task automatic drain_results();
		s_tvalid <= 1'b0;
		while (frame_results_due.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
		drain_results();
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!(cfg_valid && cfg_ready));
		cfg_valid <= 1'b0;
		case (idx)
			CFG_HDR_FIRST:  cfg_hf = val[7:0];
			CFG_HDR_SECOND: cfg_hs = val[7:0];
			CFG_TIMEOUT:    cfg_timeout = val;
			default: ;
		endcase
		n_cfg++;
	endtask

	task automatic random_traffic(input int target, input int tick_pct, input int max_len);
		int sel;
		int len;
		int start;
		start = frame_items;
		while (frame_items - start < target) begin
			if ($urandom_range(0, 7) == 0)
				tx_no_idle = !tx_no_idle;
			if ($urandom_range(0, 7) == 0)
				rx_no_idle = !rx_no_idle;
			sel = $urandom_range(0, 99);
			len = ($urandom_range(0, 3) == 0) ? $urandom_range(0, max_len) : $urandom_range(0, 6);
			if (sel < 65) begin
				send_frame(len, 1'b0, 1000, tick_pct);
			end else if (sel < 78) begin
				send_frame(len, 1'b1, 1000, tick_pct);
			end else if (sel < 88) begin
				send_frame(len, 1'b0, $urandom_range(1, len + 4), tick_pct);
			end else begin
				repeat ($urandom_range(1, 4))
					send_checked(1'($urandom_range(0, 1)), 8'($urandom));
			end
		end
		tx_no_idle = 1'b0;
		rx_no_idle = 1'b0;
	endtask

	// result check
	always @(posedge clk) begin
		if (arst_n && s_tvalid && !s_tready)
			n_stall++;
		if (arst_n && m_tvalid && m_tready) begin
			if (frame_results_due.size() == 0) begin
				$error("unexpected result: kind %0d, tdata %h", m_tuser, m_tdata);
				n_fail++;
			end else begin
				want = frame_results_due.pop_front();
				if (m_tuser != want.kind) begin
					$error("kind: expected %0d, actual %0d", want.kind, m_tuser);
					n_fail++;
				end
				if (m_tdata[7:0] != want.payload_byte) begin
					$error("payload_byte: expected %h, actual %h", want.payload_byte,
						m_tdata[7:0]);
					n_fail++;
				end
				if (m_tdata[15:8] != want.payload_index) begin
					$error("payload_index: expected %0d, actual %0d", want.payload_index,
						m_tdata[15:8]);
					n_fail++;
				end
				if (m_tdata[23:16] != want.frame_length) begin
					$error("frame_length: expected %0d, actual %0d", want.frame_length,
						m_tdata[23:16]);
					n_fail++;
				end
				case (want.kind)
					KIND_PAYLOAD: n_payload++;
					KIND_GOOD:    n_good++;
					default:      n_bad++;
				endcase
			end
		end
	end

	// result side, with per-item stalls and one long hold-off on request
	initial begin : rx_side
		int gap;
		m_tready = 1'b0;
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (hold_out_req) begin
				hold_out_req = 1'b0;
				m_tready <= 1'b0;
				repeat (RX_HOLD_CYCLES) @(posedge clk);
			end
			gap = rx_no_idle ? 0 : $urandom_range(0, 15);
			if (gap != 0) begin
				m_tready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!(m_tvalid && m_tready));
		end
	end

	initial begin
		#4000000;
		$display("Simulation FAILED");
		$finish;
	end

	initial begin : stimulus
		stim_row_t  row;
		logic [7:0] b;
		bit         got;
		result_t    r;
		int         i;
		int         waited;
		logic [7:0] hdr;

		arst_n    = 1'b0;
		s_tvalid  = 1'b0;
		s_tdata   = 8'h00;
		s_tuser   = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = CFG_HDR_FIRST;
		cfg_data  = 16'h0000;
		tx_no_idle   = 1'b0;
		rx_no_idle   = 1'b0;
		hold_out_req = 1'b0;
		deframer_reset();

		// reset headers 55 aa, crc of a lone zero length byte is 40bf
		add_row(1'b0, FROM_LIT,    8'h55, CHK_NONE,   KIND_PAYLOAD, 8'h00, 8'h00, 8'h00);
		add_row(1'b0, FROM_LIT,    8'hAA, CHK_NONE,   KIND_PAYLOAD, 8'h00, 8'h00, 8'h00);
		add_row(1'b0, FROM_LIT,    8'h00, CHK_NONE,   KIND_PAYLOAD, 8'h00, 8'h00, 8'h00);
		add_row(1'b0, FROM_LIT,    8'h40, CHK_NONE,   KIND_PAYLOAD, 8'h00, 8'h00, 8'h00);
		add_row(1'b0, FROM_LIT,    8'hBF, CHK_RESULT, KIND_GOOD,    8'h00, 8'h00, 8'h00);
		add_row(1'b0, FROM_LIT,    8'h55, CHK_NONE,   KIND_PAYLOAD, 8'h00, 8'h00, 8'h00);
		add_row(1'b0, FROM_LIT,    8'hAA, CHK_NONE,   KIND_PAYLOAD, 8'h00, 8'h00, 8'h00);
		add_row(1'b0, FROM_LIT,    8'h00, CHK_NONE,   KIND_PAYLOAD, 8'h00, 8'h00, 8'h00);
		add_row(1'b0, FROM_LIT,    8'h40, CHK_NONE,   KIND_PAYLOAD, 8'h00, 8'h00, 8'h00);
		add_row(1'b0, FROM_LIT,    8'hBE, CHK_RESULT, KIND_BAD,     8'h00, 8'h00, 8'h00);
		// wrong second header that equals the first header is not reused
		add_row(1'b0, FROM_LIT,    8'h55, CHK_NONE,   KIND_PAYLOAD, 8'h00, 8'h00, 8'h00);
		add_row(1'b0, FROM_LIT,    8'h55, CHK_NONE,   KIND_PAYLOAD, 8'h00, 8'h00, 8'h00);
		add_row(1'b0, FROM_LIT,    8'hAA, CHK_NONE,   KIND_PAYLOAD, 8'h00, 8'h00, 8'h00);
		add_row(1'b1, FROM_LIT,    8'hFF, CHK_NONE,   KIND_PAYLOAD, 8'h00, 8'h00, 8'h00);
		add_row(1'b0, FROM_LIT,    8'h55, CHK_NONE,   KIND_PAYLOAD, 8'h00, 8'h00, 8'h00);
		add_row(1'b0, FROM_LIT,    8'hAA, CHK_NONE,   KIND_PAYLOAD, 8'h00, 8'h00, 8'h00);
		add_row(1'b0, FROM_LIT,    8'h02, CHK_NONE,   KIND_PAYLOAD, 8'h00, 8'h00, 8'h00);
		add_row(1'b0, FROM_LIT,    8'hFF, CHK_RESULT, KIND_PAYLOAD, 8'hFF, 8'h00, 8'h02);
		add_row(1'b0, FROM_LIT,    8'h00, CHK_RESULT, KIND_PAYLOAD, 8'h00, 8'h01, 8'h02);
		add_row(1'b0, FROM_CRC_HI, 8'h00, CHK_MODEL,  KIND_PAYLOAD, 8'h00, 8'h00, 8'h00);
		add_row(1'b0, FROM_CRC_LO, 8'h00, CHK_RESULT, KIND_GOOD,    8'h00, 8'h00, 8'h02);
		add_row(1'b1, FROM_LIT,    8'h00, CHK_NONE,   KIND_PAYLOAD, 8'h00, 8'h00, 8'h00);

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (i = 0; i < directed_rows.size(); i++) begin
			row = directed_rows[i];
			case (row.src)
				FROM_LIT:    b = row.lit;
				FROM_CRC_HI: b = fr_crc[15:8];
				default:     b = fr_crc[7:0];
			endcase
			send_item(row.op, b, got, r);
			if (row.chk == CHK_MODEL && got)
				frame_results_due.push_back(r);
			else if (row.chk == CHK_RESULT)
				frame_results_due.push_back(row.res);
		end

		// shortest timeout: one tick makes a partial frame stale
		write_reg(CFG_HDR_FIRST, 16'h0000);
		write_reg(CFG_HDR_SECOND, 16'h00FF);
		write_reg(CFG_TIMEOUT, 16'd1);
		send_checked(1'b0, 8'h00);
		send_checked(1'b0, 8'hFF);
		send_checked(1'b0, 8'h03);
		send_checked(1'b0, 8'h5A);
		send_ticks(1);
		send_checked(1'b0, 8'h37);
		send_frame(2, 1'b0, 1000, 0);

		// longest timeout, a run of ticks leaves the partial frame alone
		write_reg(CFG_TIMEOUT, 16'hFFFF);
		send_checked(1'b0, 8'h00);
		send_checked(1'b0, 8'hFF);
		send_checked(1'b0, 8'h04);
		send_checked(1'b0, 8'hA5);
		tx_no_idle = 1'b1;
		rx_no_idle = 1'b1;
		send_ticks(20);
		tx_no_idle = 1'b0;
		rx_no_idle = 1'b0;
		send_checked(1'b0, 8'h12);
		send_frame(3, 1'b0, 1000, 0);

		// random headers, moderate timeout
		write_reg(CFG_HDR_FIRST, 16'($urandom_range(0, 255)));
		write_reg(CFG_HDR_SECOND, 16'($urandom_range(0, 255)));
		write_reg(CFG_TIMEOUT, 16'($urandom_range(30, 300)));
		random_traffic(FRAME_TARGET / 4, 10, 24);

		// equal headers, no timeout in practice, back-pressure and a pause
		hdr = 8'($urandom);
		write_reg(CFG_HDR_FIRST, {8'h00, hdr});
		write_reg(CFG_HDR_SECOND, {8'h00, hdr});
		write_reg(CFG_TIMEOUT, 16'hFFFF);
		tx_no_idle   = 1'b1;
		hold_out_req = 1'b1;
		send_frame(255, 1'b0, 1000, 0);
		tx_no_idle = 1'b0;
		random_traffic(FRAME_TARGET / 8, 5, 24);
		drain_results();
		random_traffic(FRAME_TARGET / 8, 5, 24);

		// very short timeouts, frequent ticks
		write_reg(CFG_HDR_FIRST, 16'($urandom_range(0, 255)));
		write_reg(CFG_HDR_SECOND, 16'($urandom_range(0, 255)));
		write_reg(CFG_TIMEOUT, 16'($urandom_range(1, 12)));
		random_traffic(FRAME_TARGET / 2, 20, 16);

		s_tvalid <= 1'b0;
		waited = 0;
		while (frame_results_due.size() != 0 && waited < 20000) begin
			@(posedge clk);
			waited++;
		end
		repeat (8) @(posedge clk);
		if (frame_results_due.size() != 0) begin
			$error("%0d expected results never arrived", frame_results_due.size());
			n_fail++;
		end

		$display("covered %0d items, %0d of them in frames; %0d payload bytes checked",
			n_items, frame_items, n_payload);
		$display("verdicts %0d good / %0d bad, %0d register writes, %0d input stall cycles",
			n_good, n_bad, n_cfg, n_stall);
		if (n_fail == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule

FILE: serial_frame_receiver_crc16_top.f
rtl/sfr_pkg.sv
rtl/sfr_parser.sv
rtl/sfr_out_reg.sv
rtl/serial_frame_receiver_crc16_top.sv
test/tb_top.sv
